### design/wav_pkg.sv
`timescale 1ns / 1ps

package wav_pkg;

    typedef enum logic [2:0] {
        PH_RIFF = 3'd0,
        PH_CHDR = 3'd1,
        PH_FMT  = 3'd2,
        PH_SKIP = 3'd3,
        PH_PAD  = 3'd4,
        PH_DATA = 3'd5,
        PH_DONE = 3'd6,
        PH_ERR  = 3'd7
    } t_phase;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_SAMPLE = 2'd0;
    localparam t_kind KIND_END    = 2'd1;
    localparam t_kind KIND_ERROR  = 2'd2;

    typedef logic [2:0] t_err;
    localparam t_err ERR_TAG     = 3'd0;
    localparam t_err ERR_NO_DATA = 3'd1;
    localparam t_err ERR_FMT     = 3'd2;
    localparam t_err ERR_NOT_PCM = 3'd3;
    localparam t_err ERR_CHANS   = 3'd4;
    localparam t_err ERR_DEPTH   = 3'd5;

    localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
    localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
    localparam logic [31:0] TAG_FMT  = 32'h666d_7420;
    localparam logic [31:0] TAG_DATA = 32'h6461_7461;

    // Result queue: room is reserved for the worst case of three results per byte.
    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = 3;
    localparam int MAX_RES    = 3;

    typedef struct packed {
        t_kind              kind;
        logic signed [15:0] sample_value;
        logic               channel_index;
        logic [1:0]         num_channels;
        logic [31:0]        sample_rate;
        logic [4:0]         bits_per_sample;
        logic [31:0]        frame_count;
        t_err               error_code;
        logic               last;
    } t_result;

endpackage

### design/wav_pcm_stream_decoder.sv
`timescale 1ns / 1ps

// WAV PCM stream decoder. Feed the file one byte per transaction on the slave side,
// with tlast on the final byte; results come out on the master side, one per
// transaction: tuser gives the kind (sample, end of file, error) and tlast marks the
// final result of a file. A byte can be taken every cycle. Each byte is registered,
// parsed in the next cycle and its results (none, one or two samples or an error, plus
// an end or error result on the last byte, three at most) go into an 8-entry result
// queue that drains one result per cycle while m_axis_tready is high; tvalid for the
// first result of a byte rises once its results have been written into the queue.
// tready drops only while the queue lacks room for the worst case of the
// byte in flight and the next one, so the sustained rate is one byte per cycle as long
// as results are taken as fast as they are made.
module wav_pcm_stream_decoder
    import wav_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // file_byte
    input  logic        s_axis_tlast,   // end_of_file
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // sample_value[15:0], channel_index[16], num_channels[18:17], sample_rate[50:19],
    // bits_per_sample[55:51], frame_count[87:56], error_code[90:88], zero[95:91]
    output logic [95:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser,   // kind
    output logic        m_axis_tlast    // last
);

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // parse state
    t_phase      r_phase, n_phase;
    logic [3:0]  r_pos, n_pos;
    logic [31:0] r_tag, n_tag;
    logic [31:0] r_left, n_left;
    logic        r_pad, n_pad;
    logic        r_fmt_seen, n_fmt_seen;
    logic        r_fmt_long, n_fmt_long;
    logic [15:0] r_fmt_tag, n_fmt_tag;
    logic [15:0] r_chan, n_chan;
    logic [31:0] r_rate, n_rate;
    logic [15:0] r_depth, n_depth;
    logic [23:0] r_acc, n_acc;
    logic [1:0]  r_sbp, n_sbp;
    logic [15:0] r_held, n_held;
    logic [31:0] r_frames, n_frames;

    // result queue
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_count;
    t_result              res [MAX_RES];
    logic [1:0]           n_res;
    logic                 pop;
    logic [FIFO_AW:0]     need;

    function automatic t_result mk(t_kind kind, logic [15:0] smp, logic ch, logic withfmt,
                                   logic [15:0] chan, logic [31:0] rate, logic [15:0] depth,
                                   logic [31:0] frames, t_err err, logic lst);
        t_result r;
        r.kind            = kind;
        r.sample_value    = smp;
        r.channel_index   = ch;
        r.num_channels    = withfmt ? chan[1:0] : 2'd0;
        r.sample_rate     = withfmt ? rate : 32'd0;
        r.bits_per_sample = withfmt ? depth[4:0] : 5'd0;
        r.frame_count     = frames;
        r.error_code      = err;
        r.last            = lst;
        return r;
    endfunction

    assign need          = r_count + (r_in_valid ? (FIFO_AW+1)'(MAX_RES) : '0);
    assign s_axis_tready = need <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_RES);
    assign pop           = m_axis_tvalid && m_axis_tready;

    always_comb begin
        logic [7:0]  b;
        logic [3:0]  p;
        logic [1:0]  sp;
        logic [1:0]  nbytes;
        logic [15:0] s;
        logic        fmt_ok;
        t_err        ferr;

        n_phase    = r_phase;
        n_pos      = r_pos;
        n_tag      = r_tag;
        n_left     = r_left;
        n_pad      = r_pad;
        n_fmt_seen = r_fmt_seen;
        n_fmt_long = r_fmt_long;
        n_fmt_tag  = r_fmt_tag;
        n_chan     = r_chan;
        n_rate     = r_rate;
        n_depth    = r_depth;
        n_acc      = r_acc;
        n_sbp      = r_sbp;
        n_held     = r_held;
        n_frames   = r_frames;
        n_res      = 2'd0;
        for (int k = 0; k < MAX_RES; k++) begin
            res[k] = '0;
        end
        b      = r_in_byte;
        p      = r_pos;
        sp     = r_sbp;
        nbytes = r_depth[4:3];
        s      = '0;
        fmt_ok = 1'b0;
        ferr   = ERR_FMT;

        if (r_in_valid) begin
            unique case (r_phase)
                PH_RIFF: begin
                    n_tag = {r_tag[23:0], b};
                    if ((p == 4'd3 && n_tag != TAG_RIFF) || (p == 4'd11 && n_tag != TAG_WAVE)) begin
                        res[0]  = mk(KIND_ERROR, '0, 1'b0, 1'b0, r_chan, r_rate, r_depth,
                                     '0, ERR_TAG, 1'b1);
                        n_res   = 2'd1;
                        n_phase = PH_ERR;
                    end else if (p == 4'd11) begin
                        n_phase = PH_CHDR;
                        n_pos   = '0;
                    end else begin
                        n_pos = p + 4'd1;
                    end
                end
                PH_CHDR: begin
                    if (p < 4'd4) begin
                        n_tag = {r_tag[23:0], b};
                        n_pos = p + 4'd1;
                    end else begin
                        if (p == 4'd4) begin
                            n_left = {24'd0, b};
                        end else begin
                            n_left = r_left | ({24'd0, b} << {p[1:0], 3'b000});
                        end
                        if (p < 4'd7) begin
                            n_pos = p + 4'd1;
                        end else begin
                            n_pad = n_left[0];
                            n_pos = '0;
                            if (r_tag == TAG_FMT) begin
                                n_fmt_seen = 1'b1;
                                n_fmt_long = n_left >= 32'd16;
                                n_fmt_tag  = '0;
                                n_chan     = '0;
                                n_rate     = '0;
                                n_depth    = '0;
                                if (n_left == '0) begin
                                    n_phase = n_pad ? PH_PAD : PH_CHDR;
                                end else begin
                                    n_phase = PH_FMT;
                                end
                            end else if (r_tag == TAG_DATA) begin
                                priority if (!r_fmt_seen || !r_fmt_long) begin
                                    ferr = ERR_FMT;
                                end else if (r_fmt_tag != 16'd1) begin
                                    ferr = ERR_NOT_PCM;
                                end else if (r_chan != 16'd1 && r_chan != 16'd2) begin
                                    ferr = ERR_CHANS;
                                end else if (r_depth != 16'd8 && r_depth != 16'd16
                                             && r_depth != 16'd24) begin
                                    ferr = ERR_DEPTH;
                                end else begin
                                    fmt_ok = 1'b1;
                                end
                                if (!fmt_ok) begin
                                    res[0]  = mk(KIND_ERROR, '0, 1'b0, 1'b0, r_chan, r_rate,
                                                 r_depth, '0, ferr, 1'b1);
                                    n_res   = 2'd1;
                                    n_phase = PH_ERR;
                                end else begin
                                    n_acc   = '0;
                                    n_sbp   = '0;
                                    n_held  = '0;
                                    n_phase = (n_left == '0) ? PH_DONE : PH_DATA;
                                end
                            end else begin
                                if (n_left == '0) begin
                                    n_phase = n_pad ? PH_PAD : PH_CHDR;
                                end else begin
                                    n_phase = PH_SKIP;
                                end
                            end
                        end
                    end
                end
                PH_FMT: begin
                    if (p < 4'd2) begin
                        n_fmt_tag[{p[0], 3'b000} +: 8] = r_fmt_tag[{p[0], 3'b000} +: 8] | b;
                    end else if (p < 4'd4) begin
                        n_chan[{p[0], 3'b000} +: 8] = r_chan[{p[0], 3'b000} +: 8] | b;
                    end else if (p < 4'd8) begin
                        n_rate[{p[1:0], 3'b000} +: 8] = r_rate[{p[1:0], 3'b000} +: 8] | b;
                    end else if (p >= 4'd14) begin
                        n_depth[{p[0], 3'b000} +: 8] = r_depth[{p[0], 3'b000} +: 8] | b;
                    end
                    n_left = r_left - 32'd1;
                    if (n_left == '0) begin
                        n_phase = r_pad ? PH_PAD : PH_CHDR;
                        n_pos   = '0;
                    end else if (p == 4'd15) begin
                        n_phase = PH_SKIP;
                    end else begin
                        n_pos = p + 4'd1;
                    end
                end
                PH_SKIP: begin
                    n_left = r_left - 32'd1;
                    if (n_left == '0) begin
                        n_phase = r_pad ? PH_PAD : PH_CHDR;
                        n_pos   = '0;
                    end
                end
                PH_PAD: begin
                    n_phase = PH_CHDR;
                    n_pos   = '0;
                end
                PH_DATA: begin
                    n_acc = ((sp == 2'd0) ? 24'd0 : r_acc) | ({16'd0, b} << {sp, 3'b000});
                    n_sbp = sp + 2'd1;
                    if (n_sbp >= nbytes) begin
                        unique case (nbytes)
                            2'd1:    s = {~n_acc[7], n_acc[6:0], 8'h00};
                            2'd2:    s = n_acc[15:0];
                            default: s = n_acc[23:8];
                        endcase
                        n_sbp = '0;
                        if (r_chan == 16'd1) begin
                            n_frames = r_frames + 32'd1;
                            res[0]   = mk(KIND_SAMPLE, s, 1'b0, 1'b1, r_chan, r_rate, r_depth,
                                          n_frames, ERR_TAG, 1'b0);
                            n_res    = 2'd1;
                        end else if (!r_pos[0]) begin
                            // hold the left sample until its right partner arrives
                            n_held = s;
                            n_pos  = 4'd1;
                        end else begin
                            n_frames = r_frames + 32'd1;
                            res[0]   = mk(KIND_SAMPLE, r_held, 1'b0, 1'b1, r_chan, r_rate,
                                          r_depth, n_frames, ERR_TAG, 1'b0);
                            res[1]   = mk(KIND_SAMPLE, s, 1'b1, 1'b1, r_chan, r_rate, r_depth,
                                          n_frames, ERR_TAG, 1'b0);
                            n_res    = 2'd2;
                            n_pos    = '0;
                        end
                    end
                    n_left = r_left - 32'd1;
                    if (n_left == '0) begin
                        n_phase = PH_DONE;
                    end
                end
                PH_DONE, PH_ERR: begin
                end
            endcase

            if (r_in_last) begin
                if (n_phase == PH_DATA || n_phase == PH_DONE) begin
                    res[n_res] = mk(KIND_END, '0, 1'b0, 1'b1, n_chan, n_rate, n_depth,
                                    n_frames, ERR_TAG, 1'b1);
                    n_res      = n_res + 2'd1;
                end else if (n_phase == PH_RIFF) begin
                    res[n_res] = mk(KIND_ERROR, '0, 1'b0, 1'b0, n_chan, n_rate, n_depth,
                                    '0, ERR_TAG, 1'b1);
                    n_res      = n_res + 2'd1;
                end else if (n_phase != PH_ERR) begin
                    res[n_res] = mk(KIND_ERROR, '0, 1'b0, 1'b0, n_chan, n_rate, n_depth,
                                    '0, ERR_NO_DATA, 1'b1);
                    n_res      = n_res + 2'd1;
                end
                // restart for the next file
                n_phase    = PH_RIFF;
                n_pos      = '0;
                n_tag      = '0;
                n_left     = '0;
                n_pad      = 1'b0;
                n_fmt_seen = 1'b0;
                n_fmt_long = 1'b0;
                n_fmt_tag  = '0;
                n_chan     = '0;
                n_rate     = '0;
                n_depth    = '0;
                n_acc      = '0;
                n_sbp      = '0;
                n_held     = '0;
                n_frames   = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_phase    <= PH_RIFF;
            r_pos      <= '0;
            r_tag      <= '0;
            r_left     <= '0;
            r_pad      <= 1'b0;
            r_fmt_seen <= 1'b0;
            r_fmt_long <= 1'b0;
            r_fmt_tag  <= '0;
            r_chan     <= '0;
            r_rate     <= '0;
            r_depth    <= '0;
            r_acc      <= '0;
            r_sbp      <= '0;
            r_held     <= '0;
            r_frames   <= '0;
            r_wr       <= '0;
            r_rd       <= '0;
            r_count    <= '0;
        end else begin
            r_in_valid <= s_axis_tvalid && s_axis_tready;
            r_phase    <= n_phase;
            r_pos      <= n_pos;
            r_tag      <= n_tag;
            r_left     <= n_left;
            r_pad      <= n_pad;
            r_fmt_seen <= n_fmt_seen;
            r_fmt_long <= n_fmt_long;
            r_fmt_tag  <= n_fmt_tag;
            r_chan     <= n_chan;
            r_rate     <= n_rate;
            r_depth    <= n_depth;
            r_acc      <= n_acc;
            r_sbp      <= n_sbp;
            r_held     <= n_held;
            r_frames   <= n_frames;
            r_wr       <= r_wr + FIFO_AW'(n_res);
            r_rd       <= r_rd + FIFO_AW'(pop);
            r_count    <= r_count + (FIFO_AW+1)'(n_res) - (FIFO_AW+1)'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_last <= s_axis_tlast;
        end
        for (int k = 0; k < MAX_RES; k++) begin
            if (2'(k) < n_res) begin
                r_fifo[r_wr + FIFO_AW'(k)] <= res[k];
            end
        end
    end

    t_result head;
    assign head          = r_fifo[r_rd];
    assign m_axis_tvalid = r_count != '0;
    assign m_axis_tuser  = head.kind;
    assign m_axis_tlast  = head.last;
    assign m_axis_tdata  = {5'd0, head.error_code, head.frame_count, head.bits_per_sample,
                            head.sample_rate, head.num_channels, head.channel_index,
                            head.sample_value};

endmodule

### design/wav_checker.sv
`timescale 1ns / 1ps

module wav_checker
    import wav_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        s_axis_tlast,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("result changed while stalled");

    // samples never close a file; end and error results always do
    a_last_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> ((m_axis_tuser == KIND_SAMPLE) != m_axis_tlast)
            && (m_axis_tuser == KIND_SAMPLE || m_axis_tuser == KIND_END
                || m_axis_tuser == KIND_ERROR))
        else $error("bad kind or last flag");

    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |->
            (m_axis_tuser != KIND_ERROR || m_axis_tdata[87:0] == '0)
            && (m_axis_tuser != KIND_SAMPLE
                || (m_axis_tdata[90:88] == '0 && m_axis_tdata[55:51] != '0)))
        else $error("result fields do not match kind");

endmodule

bind wav_pcm_stream_decoder wav_checker u_wav_checker (.*);
